// ===== rtl/mfc_pkg.sv =====
package mfc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 3;
  localparam int MAX_HEIGHT     = 4096;

  localparam int PIX_W      = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int FR_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int OCOL_W     = 10;
  localparam int OROW_W     = 12;
  localparam int IROW_W     = 13;

  // job fields sized for the largest supported MAX_WIDTH / MAX_RADIUS
  localparam int COL_MAX_W  = 12;
  localparam int BANK_MAX_W = 5;
  localparam int RAD_MAX_W  = 3;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_WINDOW_RADIUS = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_e;

  typedef struct packed {
    logic [COL_MAX_W:0]    width;
    logic [IROW_W-1:0]     height;
    logic [RAD_MAX_W-1:0]  radius;
  } cfg_t;

  typedef struct packed {
    logic                  wr_en;
    logic [BANK_MAX_W-1:0] wr_bank;
    logic [COL_MAX_W-1:0]  wr_col;
    logic [PIX_W-1:0]      wr_data;
    logic                  emit;
    logic [COL_MAX_W-1:0]  ox;
    logic [OROW_W-1:0]     oy;
    logic [BANK_MAX_W-1:0] ob;
    logic                  last;
  } job_t;

endpackage

// ===== rtl/mfc_front.sv =====
module mfc_front #(
  parameter int MAX_WIDTH  = mfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = mfc_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [mfc_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                            job_valid_o,
  output mfc_pkg::job_t                   job_o,
  input  logic                            job_full_i,
  output mfc_pkg::cfg_t                   cfg_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_RADIUS + 1);
  localparam int NB   = 3 * MAX_RADIUS + 1;
  localparam int BW   = $clog2(NB);
  localparam int LAGW = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

  logic [mfc_pkg::FW_W-1:0]   width_q, width_d;
  logic [mfc_pkg::FH_W-1:0]   height_q, height_d;
  logic [mfc_pkg::FR_W-1:0]   radius_q, radius_d;
  logic [CW-1:0]              in_col_q, in_col_d, out_col_q, out_col_d;
  logic [mfc_pkg::IROW_W-1:0] in_row_q, in_row_d;
  logic [mfc_pkg::OROW_W-1:0] out_row_q, out_row_d;
  logic [BW-1:0]              in_bank_q, in_bank_d, out_bank_q, out_bank_d;
  logic [LAGW-1:0]            pend_q, pend_d;

  logic [WW-1:0]              w_eff;
  logic [mfc_pkg::IROW_W-1:0] h_eff;
  logic [RW-1:0]              r_eff;
  logic [LAGW-1:0]            lag;
  logic accept, is_pix, is_drain, do_emit, clear;
  logic in_col_last, out_col_last, out_row_last;

  always_comb begin
    if (width_q == '0) w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_q);
    if (height_q == '0) h_eff = mfc_pkg::IROW_W'(1);
    else if (32'(height_q) > mfc_pkg::MAX_HEIGHT) h_eff = mfc_pkg::IROW_W'(mfc_pkg::MAX_HEIGHT);
    else h_eff = height_q;
    if (32'(radius_q) > MAX_RADIUS) r_eff = RW'(MAX_RADIUS);
    else r_eff = RW'(radius_q);
  end

  assign lag = LAGW'(LAGW'(r_eff) * LAGW'(w_eff) + LAGW'(r_eff));

  assign cfg_o.width  = (mfc_pkg::COL_MAX_W + 1)'(w_eff);
  assign cfg_o.height = h_eff;
  assign cfg_o.radius = mfc_pkg::RAD_MAX_W'(r_eff);

  assign in_ready_o   = !job_full_i;
  assign accept       = in_valid_i && in_ready_o;
  assign is_pix       = (mfc_pkg::op_e'(operation_i) == mfc_pkg::OP_PIXEL) && (in_row_q < h_eff);
  assign is_drain     = !is_pix && (in_row_q >= h_eff);
  assign do_emit      = is_pix ? (pend_q >= lag) : is_drain;
  assign in_col_last  = (WW'(in_col_q) == w_eff - WW'(1));
  assign out_col_last = (WW'(out_col_q) == w_eff - WW'(1));
  assign out_row_last = ({1'b0, out_row_q} == h_eff - mfc_pkg::IROW_W'(1));

  assign job_valid_o   = accept && (is_pix || do_emit);
  assign job_o.wr_en   = is_pix;
  assign job_o.wr_bank = mfc_pkg::BANK_MAX_W'(in_bank_q);
  assign job_o.wr_col  = mfc_pkg::COL_MAX_W'(in_col_q);
  assign job_o.wr_data = pixel_value_i;
  assign job_o.emit    = do_emit;
  assign job_o.ox      = mfc_pkg::COL_MAX_W'(out_col_q);
  assign job_o.oy      = out_row_q;
  assign job_o.ob      = mfc_pkg::BANK_MAX_W'(out_bank_q);
  assign job_o.last    = out_col_last && out_row_last;

  always_comb begin
    width_d    = width_q;
    height_d   = height_q;
    radius_d   = radius_q;
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    in_bank_d  = in_bank_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_bank_d = out_bank_q;
    pend_d     = pend_q;
    clear      = 1'b0;
    if (cfg_we_i) begin
      clear = 1'b1;
      unique case (mfc_pkg::reg_idx_e'(cfg_index_i))
        mfc_pkg::REG_FRAME_WIDTH:   width_d  = mfc_pkg::FW_W'(cfg_data_i);
        mfc_pkg::REG_FRAME_HEIGHT:  height_d = mfc_pkg::FH_W'(cfg_data_i);
        mfc_pkg::REG_WINDOW_RADIUS: radius_d = mfc_pkg::FR_W'(cfg_data_i);
        default:                    clear    = 1'b0;
      endcase
    end else if (accept) begin
      if (is_pix) begin
        if (in_col_last) begin
          in_col_d  = '0;
          in_row_d  = in_row_q + mfc_pkg::IROW_W'(1);
          in_bank_d = (in_bank_q == BW'(NB - 1)) ? '0 : in_bank_q + BW'(1);
        end else begin
          in_col_d = in_col_q + CW'(1);
        end
        if (!do_emit) pend_d = pend_q + LAGW'(1);
      end else if (is_drain) begin
        pend_d = pend_q - LAGW'(1);
      end
      if (do_emit) begin
        if (out_col_last) begin
          out_col_d  = '0;
          out_row_d  = out_row_q + mfc_pkg::OROW_W'(1);
          out_bank_d = (out_bank_q == BW'(NB - 1)) ? '0 : out_bank_q + BW'(1);
          if (out_row_last) clear = 1'b1;
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
    end
    if (clear) begin
      in_col_d   = '0;
      in_row_d   = '0;
      in_bank_d  = '0;
      out_col_d  = '0;
      out_row_d  = '0;
      out_bank_d = '0;
      pend_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= mfc_pkg::FW_W'(1024);
      height_q   <= mfc_pkg::FH_W'(1024);
      radius_q   <= mfc_pkg::FR_W'(1);
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_bank_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_bank_q <= '0;
      pend_q     <= '0;
    end else begin
      width_q    <= width_d;
      height_q   <= height_d;
      radius_q   <= radius_d;
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_bank_q  <= in_bank_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_bank_q <= out_bank_d;
      pend_q     <= pend_d;
    end
  end

endmodule

// ===== rtl/mfc_queue.sv =====
module mfc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfc_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mfc_pkg::job_t data_o
);

  localparam int PW = $clog2(mfc_pkg::QUEUE_DEPTH);

  mfc_pkg::job_t mem_q [mfc_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign full_o  = (count_q == (PW + 1)'(mfc_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push_i && !pop_i) count_q <= count_q + (PW + 1)'(1);
      else if (pop_i && !push_i) count_q <= count_q - (PW + 1)'(1);
    end
  end

endmodule

// ===== rtl/mfc_back.sv =====
module mfc_back #(
  parameter int MAX_WIDTH  = mfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = mfc_pkg::MAX_RADIUS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mfc_pkg::cfg_t                 cfg_i,
  input  logic                          job_valid_i,
  input  mfc_pkg::job_t                 job_i,
  output logic                          job_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mfc_pkg::PIX_W-1:0]     filtered_value_o,
  output logic [mfc_pkg::OCOL_W-1:0]    out_column_o,
  output logic [mfc_pkg::OROW_W-1:0]    out_row_o,
  output logic                          frame_end_o
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_RADIUS + 1);
  localparam int NB  = 3 * MAX_RADIUS + 1;
  localparam int BW  = $clog2(NB);
  localparam int NW  = 2 * MAX_RADIUS + 1;
  localparam int NE  = NW * NW;
  localparam int RKW = $clog2(NE + 1);
  localparam int PW  = mfc_pkg::PIX_W;
  localparam int YW  = mfc_pkg::OROW_W;

  logic [CW:0]                w;
  logic [mfc_pkg::IROW_W-1:0] h;
  logic [RW-1:0]              r;

  assign w = (CW + 1)'(cfg_i.width);
  assign h = cfg_i.height;
  assign r = RW'(cfg_i.radius);

  logic adv;

  // window fetch
  logic [RW-1:0]   sub_q;
  logic            preload, step, wr, rowstart, cv, emit0;
  logic [BW-1:0]   wbank, ob;
  logic [CW-1:0]   wcol, ox, raddr;
  logic [CW:0]     rcol;
  logic [NW-1:0]   rv;
  logic [NW-1:0][BW-1:0] bsel;
  logic signed [YW+1:0]  row_s;
  logic signed [BW+1:0]  bsum;
  logic [NB-1:0][PW-1:0] rd_data;

  logic                  m1_valid_q;
  logic                  m1_push_q, m1_rowstart_q, m1_cv_q, m1_emit_q, m1_last_q;
  logic [CW-1:0]         m1_ox_q;
  logic [YW-1:0]         m1_oy_q;
  logic [NW-1:0]         m1_rv_q;
  logic [NW-1:0][BW-1:0] m1_bsel_q;

  assign adv     = !out_valid_o || out_ready_i;
  assign ox      = CW'(job_i.ox);
  assign ob      = BW'(job_i.ob);
  assign wbank   = BW'(job_i.wr_bank);
  assign wcol    = CW'(job_i.wr_col);
  assign preload = job_valid_i && job_i.emit && (ox == '0) && (r != '0) && (sub_q < r);
  assign step    = adv && job_valid_i;
  assign job_pop_o = step && !preload;
  assign wr      = job_pop_o && job_i.wr_en;
  assign rcol    = preload ? (CW + 1)'(sub_q) : (CW + 1)'(ox) + (CW + 1)'(r);
  assign cv      = rcol < w;
  assign raddr   = rcol[CW-1:0];
  assign rowstart = preload ? (sub_q == '0) : (job_i.emit && (ox == '0) && (r == '0));
  assign emit0   = !preload && job_i.emit;

  always_comb begin
    row_s = '0;
    bsum  = '0;
    for (int i = 0; i < NW; i++) begin
      row_s = $signed({2'b00, job_i.oy}) + (YW + 2)'(i - MAX_RADIUS);
      rv[i] = (i >= MAX_RADIUS - int'(r)) && (i <= MAX_RADIUS + int'(r)) &&
              (row_s >= 0) && (row_s < $signed({1'b0, h}));
      bsum = $signed({2'b00, ob}) + (BW + 2)'(i - MAX_RADIUS);
      if (bsum < 0) bsel[i] = BW'(bsum + (BW + 2)'(NB));
      else if (bsum >= (BW + 2)'(NB)) bsel[i] = BW'(bsum - (BW + 2)'(NB));
      else bsel[i] = BW'(bsum);
    end
  end

  for (genvar b = 0; b < NB; b++) begin : g_bank
    logic [PW-1:0] mem [MAX_WIDTH];
    logic [PW-1:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (wr && (wbank == BW'(b))) mem[wcol] <= job_i.wr_data;
      if (adv) begin
        if (wr && (wbank == BW'(b)) && (wcol == raddr)) rd_q <= job_i.wr_data;
        else rd_q <= mem[raddr];
      end
    end
    assign rd_data[b] = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q      <= '0;
      m1_valid_q <= 1'b0;
    end else if (adv) begin
      m1_valid_q <= step;
      if (step) sub_q <= preload ? sub_q + RW'(1) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m1_push_q     <= preload || job_i.emit;
      m1_rowstart_q <= rowstart;
      m1_cv_q       <= cv;
      m1_emit_q     <= emit0;
      m1_last_q     <= job_i.last;
      m1_ox_q       <= ox;
      m1_oy_q       <= job_i.oy;
      m1_rv_q       <= rv;
      m1_bsel_q     <= bsel;
    end
  end

  // sliding window, column 0 is the newest
  logic [NW-1:0][NW-1:0][PW-1:0] win_q;
  logic [NW-1:0]                 colv_q;
  logic                          m2_valid_q, m2_last_q;
  logic [CW-1:0]                 m2_ox_q;
  logic [YW-1:0]                 m2_oy_q;
  logic [NW-1:0]                 m2_rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      colv_q     <= '0;
      m2_valid_q <= 1'b0;
    end else if (adv) begin
      m2_valid_q <= m1_valid_q && m1_emit_q;
      if (m1_valid_q && m1_push_q) begin
        colv_q[0] <= m1_cv_q;
        for (int k = 1; k < NW; k++) colv_q[k] <= m1_rowstart_q ? 1'b0 : colv_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (m1_valid_q && m1_push_q) begin
        for (int i = 0; i < NW; i++) win_q[0][i] <= rd_data[m1_bsel_q[i]];
        for (int k = 1; k < NW; k++) win_q[k] <= win_q[k-1];
      end
      m2_ox_q   <= m1_ox_q;
      m2_oy_q   <= m1_oy_q;
      m2_last_q <= m1_last_q;
      m2_rv_q   <= m1_rv_q;
    end
  end

  // rank selection: compare, count, pick
  logic [NE-1:0][PW-1:0] vals;
  logic [NE-1:0]         vm;
  logic [NE-1:0][NE-1:0] prec;

  always_comb begin
    for (int k = 0; k < NW; k++) begin
      for (int i = 0; i < NW; i++) begin
        vals[k*NW+i] = win_q[k][i];
        vm[k*NW+i]   = m2_rv_q[i] && colv_q[k] && (k <= 2 * int'(r));
      end
    end
    for (int a = 0; a < NE; a++) begin
      for (int b = 0; b < NE; b++) begin
        prec[a][b] = (a != b) && vm[b] &&
                     ((vals[b] < vals[a]) || ((vals[b] == vals[a]) && (b < a)));
      end
    end
  end

  logic                  s3_valid_q, s3_last_q;
  logic [CW-1:0]         s3_ox_q;
  logic [YW-1:0]         s3_oy_q;
  logic [NE-1:0][PW-1:0] s3_vals_q;
  logic [NE-1:0]         s3_vm_q;
  logic [NE-1:0][NE-1:0] s3_prec_q;

  logic [NE-1:0][RKW-1:0] rank;
  logic [RKW-1:0]         nvalid;

  always_comb begin
    for (int a = 0; a < NE; a++) rank[a] = RKW'($countones(s3_prec_q[a]));
    nvalid = RKW'($countones(s3_vm_q));
  end

  logic                   s4_valid_q, s4_last_q;
  logic [CW-1:0]          s4_ox_q;
  logic [YW-1:0]          s4_oy_q;
  logic [NE-1:0][PW-1:0]  s4_vals_q;
  logic [NE-1:0]          s4_vm_q;
  logic [NE-1:0][RKW-1:0] s4_rank_q;
  logic [RKW-1:0]         s4_half_q;

  logic [PW-1:0] sel_val;
  logic          sel_hit;

  always_comb begin
    sel_val = '0;
    sel_hit = 1'b0;
    for (int a = 0; a < NE; a++) begin
      if (s4_vm_q[a] && (s4_rank_q[a] == s4_half_q)) begin
        sel_val = s4_vals_q[a];
        sel_hit = 1'b1;
      end
    end
  end

  logic          out_valid_q, out_last_q;
  logic [PW-1:0] out_val_q;
  logic [CW-1:0] out_ox_q;
  logic [YW-1:0] out_oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s3_valid_q  <= m2_valid_q;
      s4_valid_q  <= s3_valid_q;
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_ox_q     <= m2_ox_q;
      s3_oy_q     <= m2_oy_q;
      s3_last_q   <= m2_last_q;
      s3_vals_q   <= vals;
      s3_vm_q     <= vm;
      s3_prec_q   <= prec;
      s4_ox_q     <= s3_ox_q;
      s4_oy_q     <= s3_oy_q;
      s4_last_q   <= s3_last_q;
      s4_vals_q   <= s3_vals_q;
      s4_vm_q     <= s3_vm_q;
      s4_rank_q   <= rank;
      s4_half_q   <= nvalid >> 1;
      out_val_q   <= sel_val;
      out_ox_q    <= s4_ox_q;
      out_oy_q    <= s4_oy_q;
      out_last_q  <= s4_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign filtered_value_o = out_val_q;
  assign out_column_o     = mfc_pkg::OCOL_W'(out_ox_q);
  assign out_row_o        = out_oy_q;
  assign frame_end_o      = out_last_q;

`ifndef SYNTHESIS
  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sub_q <= r) else $error("preload count past radius");

  a_median_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s4_valid_q |-> sel_hit) else $error("no window sample at median rank");

  a_frame_end_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |->
      (((CW + 1)'(out_ox_q) == w - (CW + 1)'(1)) &&
       ({1'b0, out_oy_q} == h - mfc_pkg::IROW_W'(1))))
    else $error("frame end flagged off the last pixel");
`endif

endmodule

// ===== rtl/median_filter_clipped_window.sv =====
// Streaming 2-D median filter over one 8-bit plane in raster order. Each result is the
// median (upper median for an even count) of the (2R+1)x(2R+1) window clipped to the
// frame. Results trail the input by R*W+R pixel transfers; after the last pixel of a
// frame, drain transfers (operation=1) push out the remaining results. Input takes one
// transfer per clock while the four-entry job queue has room; the window unit retires
// one job per clock while the output is not stalled, but at the start of every output
// row it first loads the first R columns from the line banks while holding the queue
// head. Line banks need no clearing after reset. Configuration writes to the frame
// width, frame height and window radius registers restart the frame.
module median_filter_clipped_window #(
  parameter int MAX_WIDTH  = mfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = mfc_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mfc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mfc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            operation_i,
  input  logic [mfc_pkg::PIX_W-1:0]       pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mfc_pkg::PIX_W-1:0]       filtered_value_o,
  output logic [mfc_pkg::OCOL_W-1:0]      out_column_o,
  output logic [mfc_pkg::OROW_W-1:0]      out_row_o,
  output logic                            frame_end_o
);

  mfc_pkg::cfg_t cfg;
  mfc_pkg::job_t push_job, head_job;
  logic          push, full, pop, head_valid;

  mfc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .pixel_value_i (pixel_value_i),
    .job_valid_o   (push),
    .job_o         (push_job),
    .job_full_i    (full),
    .cfg_o         (cfg)
  );

  mfc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  mfc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .job_valid_i      (head_valid),
    .job_i            (head_job),
    .job_pop_o        (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .filtered_value_o (filtered_value_o),
    .out_column_o     (out_column_o),
    .out_row_o        (out_row_o),
    .frame_end_o      (frame_end_o)
  );

endmodule

// ===== sim/median_filter_clipped_window_checker.sv =====
`timescale 1ns / 1ps

module median_filter_clipped_window_checker
  import mfc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  operation_i,
  input  logic [PIX_W-1:0]      pixel_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [PIX_W-1:0]      filtered_value_i,
  input  logic [OCOL_W-1:0]     out_column_i,
  input  logic [OROW_W-1:0]     out_row_i,
  input  logic                  frame_end_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o
);

  localparam int PLANE_DEPTH = 2 * MAX_RADIUS_DEF * MAX_WIDTH_DEF + 2 * MAX_RADIUS_DEF + 1;
  localparam int WIN_CAP     = (2 * MAX_RADIUS_DEF + 1) * (2 * MAX_RADIUS_DEF + 1);

  typedef struct packed {
    logic [PIX_W-1:0]  value;
    logic [OCOL_W-1:0] col;
    logic [OROW_W-1:0] row;
    logic              last;
  } median_px_t;

  median_px_t       median_due_q[$];
  logic [PIX_W-1:0] plane_mem [PLANE_DEPTH];
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;
  logic [FR_W-1:0]  radius_reg;
  int unsigned      in_col, in_row, out_col, out_row;

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic int unsigned eff_radius();
    if (radius_reg > MAX_RADIUS_DEF) return MAX_RADIUS_DEF;
    return radius_reg;
  endfunction

  function automatic void restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endfunction

  function automatic median_px_t window_median();
    median_px_t       res;
    logic [PIX_W-1:0] win [WIN_CAP];
    logic [PIX_W-1:0] t;
    int               n, j, y, x, rad, wid, hgt;
    rad = eff_radius();
    wid = eff_width();
    hgt = eff_height();
    n = 0;
    for (int dy = -rad; dy <= rad; dy++) begin
      y = int'(out_row) + dy;
      if (y >= 0 && y < hgt) begin
        for (int dx = -rad; dx <= rad; dx++) begin
          x = int'(out_col) + dx;
          if (x >= 0 && x < wid) begin
            win[n] = plane_mem[(y * wid + x) % PLANE_DEPTH];
            n++;
          end
        end
      end
    end
    for (int i = 1; i < n; i++) begin
      t = win[i];
      j = i;
      while (j > 0 && win[j-1] > t) begin
        win[j] = win[j-1];
        j--;
      end
      win[j] = t;
    end
    res.value = (n > 0) ? win[n/2] : '0;
    res.col   = out_col[OCOL_W-1:0];
    res.row   = out_row[OROW_W-1:0];
    res.last  = (out_row == hgt - 1) && (out_col == wid - 1);
    out_col++;
    if (out_col >= wid) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= hgt) restart_frame();
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned wid, hgt, lag, p, o, errs;
    median_px_t  exp_px;
    if (!rst_ni) begin
      width_reg  = 11'd1024;
      height_reg = 13'd1024;
      radius_reg = 2'd1;
      restart_frame();
      median_due_q.delete();
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      errs = errors_o;
      if (out_valid_i && out_ready_i) begin
        if (median_due_q.size() == 0) begin
          $error("result transfer with nothing expected (col %0d row %0d)",
                 out_column_i, out_row_i);
          errs++;
        end else begin
          exp_px = median_due_q.pop_front();
          if (filtered_value_i !== exp_px.value) begin
            $error("filtered_value: expected %0d, actual %0d", exp_px.value, filtered_value_i);
            errs++;
          end
          if (out_column_i !== exp_px.col) begin
            $error("out_column: expected %0d, actual %0d", exp_px.col, out_column_i);
            errs++;
          end
          if (out_row_i !== exp_px.row) begin
            $error("out_row: expected %0d, actual %0d", exp_px.row, out_row_i);
            errs++;
          end
          if (frame_end_i !== exp_px.last) begin
            $error("frame_end: expected %0d, actual %0d", exp_px.last, frame_end_i);
            errs++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH: begin
            width_reg = cfg_data_i[FW_W-1:0];
            restart_frame();
          end
          REG_FRAME_HEIGHT: begin
            height_reg = cfg_data_i[FH_W-1:0];
            restart_frame();
          end
          REG_WINDOW_RADIUS: begin
            radius_reg = cfg_data_i[FR_W-1:0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        wid = eff_width();
        hgt = eff_height();
        lag = eff_radius() * wid + eff_radius();
        if (operation_i == OP_PIXEL && in_row < hgt) begin
          p = in_row * wid + in_col;
          o = out_row * wid + out_col;
          plane_mem[p % PLANE_DEPTH] = pixel_value_i;
          in_col++;
          if (in_col >= wid) begin
            in_col = 0;
            in_row++;
          end
          if (p + 1 > o + lag) median_due_q.push_back(window_median());
        end else if (in_row >= hgt) begin
          median_due_q.push_back(window_median());
        end
      end
      errors_o  <= errs;
      pending_o <= median_due_q.size();
    end
  end

endmodule

// ===== sim/median_filter_clipped_window_test.sv =====
`timescale 1ns / 1ps

module median_filter_clipped_window_test;
  import mfc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE      = 32;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  operation_i = 1'b0;
  logic [PIX_W-1:0]      pixel_value_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_W-1:0]      filtered_value_o;
  logic [OCOL_W-1:0]     out_column_o;
  logic [OROW_W-1:0]     out_row_o;
  logic                  frame_end_o;

  int unsigned errors, pending, cycles, items_sent, random_items;
  bit          steady;
  bit          squeeze_done;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  median_filter_clipped_window dut (.*);

  median_filter_clipped_window_checker scoreboard (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .pixel_value_i,
    .out_valid_i(out_valid_o), .out_ready_i, .filtered_value_i(filtered_value_o),
    .out_column_i(out_column_o), .out_row_i(out_row_o), .frame_end_i(frame_end_o),
    .errors_o(errors), .pending_o(pending)
  );

  // long sink stall forces the job queue full and backs up the input
  always @(posedge clk_i) begin
    int unsigned hold;
    cycles <= cycles + 1;
    steady <= (items_sent >= 600 && items_sent < 900);
    if (!squeeze_done && items_sent >= 300) begin
      squeeze_done = 1'b1;
      hold = 400;
    end
    if (hold > 0) begin
      hold--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(99) >= 31);
    end
  end

  task automatic send_item(input op_e op, input logic [PIX_W-1:0] v);
    while (!steady && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    pixel_value_i <= v;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned w, input int unsigned h, input int unsigned r);
    wait_idle();
    write_reg(REG_WINDOW_RADIUS, CFG_DATA_W'(r));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    if ($urandom_range(3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  // raw register values; stop_at below the effective pixel count abandons the frame early
  task automatic run_frame(input int unsigned w, input int unsigned h, input int unsigned r,
                           input int unsigned stop_at);
    int unsigned ew, eh, er, npix, tail;
    ew = (w[FW_W-1:0] == 0) ? 1 : (w[FW_W-1:0] > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w[FW_W-1:0];
    eh = (h[FH_W-1:0] == 0) ? 1 : (h[FH_W-1:0] > MAX_HEIGHT) ? MAX_HEIGHT : h[FH_W-1:0];
    er = r[FR_W-1:0];
    npix = ew * eh;
    tail = (er * ew + er < npix) ? er * ew + er : npix;
    for (int unsigned i = 0; i < npix && i < stop_at; i++) begin
      if ($urandom_range(19) == 0) send_item(OP_DRAIN, PIX_W'($urandom));
      send_item(OP_PIXEL, rand_pixel());
      random_items++;
    end
    if (stop_at < npix) return;
    for (int unsigned i = 0; i < tail; i++) begin
      if ($urandom_range(9) < 7) send_item(OP_DRAIN, PIX_W'($urandom));
      else send_item(OP_PIXEL, rand_pixel());
      random_items++;
    end
    if ($urandom_range(9) == 0) send_item(OP_DRAIN, PIX_W'($urandom));
  endtask

  initial begin
    int unsigned w, h, r;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    configure(0, 0, 0);
    send_item(OP_DRAIN, 8'd0);
    send_item(OP_PIXEL, 8'd255);
    send_item(OP_PIXEL, 8'd0);
    configure(4, 3, 1);
    for (int i = 0; i < 12; i++) send_item(OP_PIXEL, (i % 3 == 0) ? 8'd0 : 8'd255);
    for (int i = 0; i < 5; i++) send_item((i == 2) ? OP_PIXEL : OP_DRAIN, 8'd255);
    send_item(OP_DRAIN, 8'd0);
    configure(3, 5, 3);
    run_frame(3, 5, 3, '1);
    configure(2, 2, 2);
    run_frame(2, 2, 2, '1);
    configure(13'h1FFF, 1, 0);
    run_frame(13'h1FFF, 1, 0, 120);
    configure(1, 13'h1FFF, 2);
    run_frame(1, 13'h1FFF, 2, 120);

    random_items = 0;
    while (random_items < 1150) begin
      w = ($urandom_range(4) == 0) ? $urandom_range(64, 25) : $urandom_range(24, 1);
      h = $urandom_range(16, 1);
      r = $urandom_range(3);
      configure(w | ($urandom_range(3) << FW_W), h, r | ($urandom_range(7) << FR_W));
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(9) == 0) run_frame(w, h, r, $urandom_range(w * h - 1));
        else run_frame(w, h, r, '1);
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("median_filter_clipped_window: match");
    end else begin
      $display("median_filter_clipped_window: mismatch");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("median_filter_clipped_window: mismatch");
    $finish;
  end

endmodule
